@@ design/psm_pkg.sv @@
// psm_pkg: shared types, constants and helpers for the power sum block
// no dependencies
package psm_pkg;

	localparam int MAX_POWER  = 32;
	localparam int W          = 31;
	localparam int BIN_ROWS   = MAX_POWER + 2;
	localparam int BIN_DEPTH  = (BIN_ROWS * (BIN_ROWS + 1)) / 2;
	localparam int BERN_DEPTH = MAX_POWER + 2;
	localparam int BIN_AW     = $clog2(BIN_DEPTH);
	localparam int BERN_AW    = $clog2(BERN_DEPTH);
	localparam int IDX_W      = 6;
	localparam logic [W-1:0] MOD_RESET = 31'd1000000007;
	localparam logic REG_MODULUS = 1'b0;

	typedef struct packed {
		logic         start;
		logic [W-1:0] a;
		logic [W-1:0] b;
		logic [W-1:0] m;
	} mm_req_t;

	typedef struct packed {
		logic         done;
		logic [W-1:0] prod;
	} mm_rsp_t;

	typedef enum logic [4:0] {
		S_BN_INIT, S_BN_ROW, S_BN_RA, S_BN_RB, S_BN_WR,
		S_IV_GO, S_IV_SQ, S_IV_SQW, S_IV_ML, S_IV_MLW,
		S_BE_SEL, S_BE_RD, S_BE_MUL, S_BE_MULW, S_BE_FIN, S_BE_FINW,
		S_IDLE, S_NR,
		S_TM_RD, S_TM_M1, S_TM_M1W, S_TM_M2, S_TM_M2W, S_TM_M3, S_TM_M3W,
		S_IV2_RD, S_FN, S_FNW, S_OUT
	} psm_state_t;

	function automatic logic [BIN_AW-1:0] row_base(input logic [IDX_W-1:0] r);
		logic [2*IDX_W:0] t;
		t = {{(IDX_W+1){1'b0}}, r} * ({{(IDX_W+1){1'b0}}, r} + (2*IDX_W+1)'(1));
		return t[BIN_AW:1];
	endfunction

	function automatic logic [W-1:0] addmod(input logic [W-1:0] a, input logic [W-1:0] b,
			input logic [W-1:0] m);
		logic [W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, m})
			s = s - {1'b0, m};
		return s[W-1:0];
	endfunction

	function automatic logic [W-1:0] negmod(input logic [W-1:0] a, input logic [W-1:0] m);
		return (a == '0) ? '0 : m - a;
	endfunction

endpackage

@@ design/psm_mulmod.sv @@
// psm_mulmod: bit-serial modular multiplier, one multiplier bit per cycle
// depends on psm_pkg
module psm_mulmod import psm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  mm_req_t req,
	output mm_rsp_t rsp
);

	logic         busy_q;
	logic         done_q;
	logic [4:0]   cnt_q;
	logic [W-1:0] acc_q;
	logic [W-1:0] a_q;
	logic [W-1:0] b_q;
	logic [W-1:0] m_q;
	logic [W:0]   dbl;
	logic [W:0]   dbl_r;
	logic [W:0]   add;
	logic [W:0]   add_r;

	always_comb begin
		dbl   = {acc_q, 1'b0};
		dbl_r = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
		add   = dbl_r + (b_q[W-1] ? {1'b0, a_q} : '0);
		add_r = (add >= {1'b0, m_q}) ? add - {1'b0, m_q} : add;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			a_q   <= req.a;
			b_q   <= req.b;
			m_q   <= req.m;
		end else if (busy_q) begin
			acc_q <= add_r[W-1:0];
			b_q   <= {b_q[W-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule

@@ design/power_sum_modulo.sv @@
// power_sum_modulo: sum of k^e for k = 1..n modulo a prime, by Faulhaber's formula
// depends on psm_pkg and psm_mulmod
//
// channel  dir  fields
// s_*      in   tdata: term_count[62:0], exponent[68:63]
// m_*      out  tdata: power_sum[30:0]
// apb      cfg  modulus at byte address 0
//
// every product goes through one bit-serial multiplier
// per item: n mod m one bit a cycle, three products a term (two for the last term)
// after reset or a modulus write the tables are rebuilt, mostly one fermat inverse
// per bernoulli entry; no item is taken meanwhile
// a waiting result does not stop the next item from being taken
module power_sum_modulo import psm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // term_count[62:0], exponent[68:63]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // power_sum[30:0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	psm_state_t state_q, state_d;
	logic [W-1:0] mod_q;
	logic         rdy_q;
	logic         ov_q;
	logic [W-1:0] out_q;

	logic [W-1:0]     bin_mem [BIN_DEPTH];
	logic [2*W-1:0]   bern_mem [BERN_DEPTH];
	logic [W-1:0]     bin_rd_q;
	logic [2*W-1:0]   bern_rd_q;
	logic [BIN_AW-1:0]  bin_raddr, bin_waddr;
	logic [BERN_AW-1:0] bern_raddr, bern_waddr;
	logic [W-1:0]     bin_wdata;
	logic [2*W-1:0]   bern_wdata;
	logic             bin_we, bern_we;

	logic [IDX_W-1:0]  r_q, c_q, p_q, k_q, j_q, e_q, nbit_q;
	logic [BIN_AW-1:0] base_q;
	logic [W-1:0]      tmp_q, pacc_q, pbase_q, sum_q, np_q, pw_q, t_q, ans_q, res_q;
	logic [4:0]        pbit_q;
	logic [62:0]       n_q;

	mm_req_t mm_req;
	mm_rsp_t mm_rsp;

	logic              cfg_ok;
	logic              in_acc;
	logic              out_load;
	logic [W-1:0]      exp_m2;
	logic              exp_bit;
	logic [IDX_W-1:0]  k_next;
	logic [BIN_AW-1:0] prev_base;
	logic [W-1:0]      bn_sum;
	logic [W:0]        nr_w;
	logic [W-1:0]      nr;
	logic [W-1:0]      tm_val;
	logic [IDX_W-1:0]  e_in;

	assign cfg_ok   = psel && penable && pwrite && pready && (paddr[2] == REG_MODULUS)
		&& (pwdata[W-1:0] >= 31'd2);
	assign in_acc   = s_tvalid && s_tready;
	assign out_load = (state_q == S_OUT) && (!ov_q || m_tready);
	assign exp_m2   = mod_q - 31'd2;
	assign exp_bit  = exp_m2[pbit_q];
	assign k_next   = (k_q == 6'd1) ? 6'd2 : k_q + 6'd2;
	assign prev_base = base_q - BIN_AW'(r_q);
	assign bn_sum   = addmod(tmp_q, (c_q < r_q) ? bin_rd_q : '0, mod_q);
	assign nr_w     = {np_q, n_q[nbit_q]};
	assign nr       = (nr_w >= {1'b0, mod_q}) ? W'(nr_w - {1'b0, mod_q}) : nr_w[W-1:0];
	assign tm_val   = j_q[0] ? negmod(mm_rsp.prod, mod_q) : mm_rsp.prod;
	assign e_in     = (s_tdata[68:63] > 6'(MAX_POWER)) ? 6'(MAX_POWER) : s_tdata[68:63];

	assign pready   = 1'b1;
	assign prdata   = {1'b0, mod_q};
	assign m_tvalid = ov_q;
	assign m_tdata  = {1'b0, out_q};

	psm_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.rsp    (mm_rsp)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_BN_INIT: state_d = S_BN_ROW;
			S_BN_ROW:  state_d = (r_q == '0) ? S_BN_ROW : S_BN_RA;
			S_BN_RA:   state_d = S_BN_RB;
			S_BN_RB:   state_d = S_BN_WR;
			S_BN_WR: begin
				if (c_q != r_q)
					state_d = S_BN_RA;
				else if (r_q == 6'(BIN_ROWS - 1))
					state_d = S_IV_GO;
				else
					state_d = S_BN_ROW;
			end
			S_IV_GO:  state_d = S_IV_SQ;
			S_IV_SQ:  state_d = S_IV_SQW;
			S_IV_SQW: begin
				if (mm_rsp.done)
					state_d = exp_bit ? S_IV_ML : ((pbit_q == '0) ? S_BE_SEL : S_IV_SQ);
			end
			S_IV_ML:  state_d = S_IV_MLW;
			S_IV_MLW: begin
				if (mm_rsp.done)
					state_d = (pbit_q == '0) ? S_BE_SEL : S_IV_SQ;
			end
			S_BE_SEL:  state_d = (p_q < 6'd2) ? S_IV_GO : S_BE_RD;
			S_BE_RD:   state_d = S_BE_MUL;
			S_BE_MUL:  state_d = S_BE_MULW;
			S_BE_MULW: begin
				if (mm_rsp.done)
					state_d = (k_next < p_q) ? S_BE_RD : S_BE_FIN;
			end
			S_BE_FIN:  state_d = S_BE_FINW;
			S_BE_FINW: begin
				if (mm_rsp.done)
					state_d = (p_q == 6'(MAX_POWER)) ? S_IDLE : S_IV_GO;
			end
			S_IDLE:   state_d = in_acc ? S_NR : S_IDLE;
			S_NR:     state_d = (nbit_q == '0) ? S_TM_RD : S_NR;
			S_TM_RD:  state_d = S_TM_M1;
			S_TM_M1:  state_d = S_TM_M1W;
			S_TM_M1W: state_d = mm_rsp.done ? S_TM_M2 : S_TM_M1W;
			S_TM_M2:  state_d = S_TM_M2W;
			S_TM_M2W: begin
				if (mm_rsp.done)
					state_d = (j_q == '0) ? S_IV2_RD : S_TM_M3;
			end
			S_TM_M3:  state_d = S_TM_M3W;
			S_TM_M3W: state_d = mm_rsp.done ? S_TM_RD : S_TM_M3W;
			S_IV2_RD: state_d = S_FN;
			S_FN:     state_d = S_FNW;
			S_FNW:    state_d = mm_rsp.done ? S_OUT : S_FNW;
			S_OUT:    state_d = out_load ? S_IDLE : S_OUT;
			default:  state_d = S_BN_INIT;
		endcase
		if (cfg_ok)
			state_d = S_BN_INIT;
	end

	always_comb begin
		s_tready   = 1'b0;
		mm_req     = '{start: 1'b0, a: '0, b: '0, m: mod_q};
		bin_raddr  = '0;
		bern_raddr = '0;
		bin_we     = 1'b0;
		bin_waddr  = base_q;
		bin_wdata  = bn_sum;
		bern_we    = 1'b0;
		bern_waddr = BERN_AW'(p_q);
		bern_wdata = {pacc_q, negmod(mm_rsp.prod, mod_q)};
		unique case (state_q)
			S_BN_ROW: begin
				bin_we    = 1'b1;
				bin_wdata = 31'd1;
			end
			S_BN_RA: bin_raddr = prev_base + BIN_AW'(c_q) - BIN_AW'(1);
			S_BN_RB: bin_raddr = prev_base + BIN_AW'(c_q);
			S_BN_WR: begin
				bin_we    = 1'b1;
				bin_waddr = base_q + BIN_AW'(c_q);
			end
			S_IV_SQ: begin
				mm_req.start = 1'b1;
				mm_req.a     = pacc_q;
				mm_req.b     = pacc_q;
			end
			S_IV_ML: begin
				mm_req.start = 1'b1;
				mm_req.a     = pacc_q;
				mm_req.b     = pbase_q;
			end
			S_BE_SEL: begin
				bern_we    = (p_q < 6'd2);
				bern_wdata = {pacc_q, (p_q == '0) ? 31'd1 : (mod_q - 31'd1) >> 1};
			end
			S_BE_RD: begin
				bin_raddr  = row_base(p_q + 6'd1) + BIN_AW'(k_q);
				bern_raddr = BERN_AW'(k_q);
			end
			S_BE_MUL: begin
				mm_req.start = 1'b1;
				mm_req.a     = bin_rd_q;
				mm_req.b     = bern_rd_q[W-1:0];
			end
			S_BE_FIN: begin
				mm_req.start = 1'b1;
				mm_req.a     = sum_q;
				mm_req.b     = pacc_q;
			end
			S_BE_FINW: bern_we = mm_rsp.done;
			S_IDLE:    s_tready = 1'b1;
			S_TM_RD: begin
				bin_raddr  = row_base(e_q + 6'd1) + BIN_AW'(j_q);
				bern_raddr = BERN_AW'(j_q);
			end
			S_TM_M1: begin
				mm_req.start = 1'b1;
				mm_req.a     = bin_rd_q;
				mm_req.b     = bern_rd_q[W-1:0];
			end
			S_TM_M2: begin
				mm_req.start = 1'b1;
				mm_req.a     = t_q;
				mm_req.b     = pw_q;
			end
			S_TM_M3: begin
				mm_req.start = 1'b1;
				mm_req.a     = pw_q;
				mm_req.b     = np_q;
			end
			S_IV2_RD: bern_raddr = BERN_AW'(e_q);
			S_FN: begin
				mm_req.start = 1'b1;
				mm_req.a     = ans_q;
				mm_req.b     = bern_rd_q[2*W-1:W];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (bin_we)
			bin_mem[bin_waddr] <= bin_wdata;
		bin_rd_q <= bin_mem[bin_raddr];
	end

	always_ff @(posedge clk) begin
		if (bern_we)
			bern_mem[bern_waddr] <= bern_wdata;
		bern_rd_q <= bern_mem[bern_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_BN_INIT;
			mod_q   <= MOD_RESET;
			rdy_q   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_ok) begin
				mod_q <= pwdata[W-1:0];
				rdy_q <= 1'b0;
			end else if (state_q == S_BE_FINW && mm_rsp.done && p_q == 6'(MAX_POWER)) begin
				rdy_q <= 1'b1;
			end
			if (out_load)
				ov_q <= 1'b1;
			else if (m_tready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load)
			out_q <= res_q;
		case (state_q)
			S_BN_INIT: begin
				r_q    <= '0;
				base_q <= '0;
			end
			S_BN_ROW: begin
				c_q <= 6'd1;
				if (r_q == '0) begin
					r_q    <= 6'd1;
					base_q <= BIN_AW'(1);
				end
			end
			S_BN_RB: tmp_q <= bin_rd_q;
			S_BN_WR: begin
				if (c_q != r_q) begin
					c_q <= c_q + 6'd1;
				end else begin
					r_q    <= r_q + 6'd1;
					base_q <= base_q + BIN_AW'(r_q) + BIN_AW'(1);
					p_q    <= '0;
				end
			end
			S_IV_GO: begin
				pacc_q  <= 31'd1;
				pbit_q  <= 5'(W - 1);
				pbase_q <= W'(p_q) + 31'd1;
			end
			S_IV_SQW: begin
				if (mm_rsp.done) begin
					pacc_q <= mm_rsp.prod;
					if (!exp_bit && pbit_q != '0)
						pbit_q <= pbit_q - 5'd1;
				end
			end
			S_IV_MLW: begin
				if (mm_rsp.done) begin
					pacc_q <= mm_rsp.prod;
					if (pbit_q != '0)
						pbit_q <= pbit_q - 5'd1;
				end
			end
			S_BE_SEL: begin
				sum_q <= 31'd1;
				k_q   <= 6'd1;
				if (p_q < 6'd2)
					p_q <= p_q + 6'd1;
			end
			S_BE_MULW: begin
				if (mm_rsp.done) begin
					sum_q <= addmod(sum_q, mm_rsp.prod, mod_q);
					k_q   <= k_next;
				end
			end
			S_BE_FINW: begin
				if (mm_rsp.done && p_q != 6'(MAX_POWER))
					p_q <= p_q + 6'd1;
			end
			S_IDLE: begin
				n_q    <= s_tdata[62:0];
				e_q    <= e_in;
				np_q   <= '0;
				nbit_q <= 6'd62;
			end
			S_NR: begin
				np_q   <= nr;
				nbit_q <= nbit_q - 6'd1;
				if (nbit_q == '0) begin
					pw_q  <= nr;
					j_q   <= e_q;
					ans_q <= '0;
				end
			end
			S_TM_M1W: begin
				if (mm_rsp.done)
					t_q <= mm_rsp.prod;
			end
			S_TM_M2W: begin
				if (mm_rsp.done)
					ans_q <= addmod(ans_q, tm_val, mod_q);
			end
			S_TM_M3W: begin
				if (mm_rsp.done) begin
					pw_q <= mm_rsp.prod;
					j_q  <= j_q - 6'd1;
				end
			end
			S_FNW: begin
				if (mm_rsp.done)
					res_q <= mm_rsp.prod;
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n) s_tready |-> rdy_q)
		else $error("item taken before tables are built");
	assert property (@(posedge clk) disable iff (!arst_n) cfg_ok |=> !rdy_q)
		else $error("tables still marked ready after modulus write");
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == S_OUT)
		else $error("result raised outside output state");

endmodule
